[rtl/lkh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lkh_pkg
// Shared types, constants and mixing functions for the lookup2 key hash.
// ----------------------------------------------------------------------------
package lkh_pkg;

    localparam logic [31:0] GOLDEN_RATIO    = 32'h9e3779b9;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [3:0]  POS_LAST        = 4'd11;
    localparam logic [3:0]  MIX_LAST_ROW    = 4'd8;

    // which accumulator a mixing row rewrites
    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;
    localparam logic [1:0] TGT_C = 2'd2;

    // one unit of work for the mixing back end
    typedef struct packed {
        logic        first;   // first job of the key: start from golden ratio and seed
        logic [31:0] seed;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] length;
        logic        blk;     // a full block to mix
        logic        fin;     // close the key and emit
    } lkh_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lkh_q_stat_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lkh_abc_t;

    function automatic logic [4:0] mix_shift(input logic [3:0] row);
        logic [4:0] sh;
        unique case (row)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [1:0] mix_target(input logic [3:0] row);
        logic [1:0] t;
        unique case (row)
            4'd0, 4'd3, 4'd6: t = TGT_A;
            4'd1, 4'd4, 4'd7: t = TGT_B;
            default:          t = TGT_C;
        endcase
        return t;
    endfunction

    // one row of the mix: two subtractions and a shifted xor
    function automatic lkh_abc_t mix_row(input lkh_abc_t s, input logic [3:0] row);
        lkh_abc_t   r;
        logic [4:0] sh;
        r  = s;
        sh = mix_shift(row);
        unique case (mix_target(row))
            TGT_A:   r.a = (s.a - s.b - s.c) ^ (s.c >> sh);
            TGT_B:   r.b = (s.b - s.c - s.a) ^ (s.a << sh);
            default: r.c = (s.c - s.a - s.b) ^ (s.b >> sh);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/lkh_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lkh_fifo
// Short job queue between the byte front end and the mixing back end.
// ----------------------------------------------------------------------------
module lkh_fifo
    import lkh_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire lkh_job_t    push_job,
    input  wire logic        pop,
    output lkh_job_t         head_job,
    output lkh_q_stat_t      q_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    lkh_job_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_job     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

[rtl/lkh_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lkh_front
// Takes key bytes, packs them into block words and queues mixing jobs.
// ----------------------------------------------------------------------------
module lkh_front
    import lkh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last_byte,
    input  wire logic [31:0] s_seed,
    input  wire lkh_q_stat_t q_stat,
    output logic             job_push,
    output lkh_job_t         job
);

    logic        in_key_reg, in_key_next;
    logic        first_reg, first_next;
    logic [31:0] seed_reg, seed_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] wa_reg, wa_next;
    logic [31:0] wb_reg, wb_next;
    logic [23:0] tail_reg, tail_next;

    logic        accept, open, cur_first, blk;
    logic [3:0]  cur_pos;
    logic [31:0] cur_len, cur_wa, cur_wb, cur_seed, placed, new_wa, new_wb, new_len;
    logic [23:0] cur_tail, new_tail;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        open      = !in_key_reg;
        cur_first = open || first_reg;
        cur_seed  = open ? s_seed : seed_reg;
        cur_pos   = open ? 4'd0 : pos_reg;
        cur_len   = open ? 32'd0 : len_reg;
        cur_wa    = open ? 32'd0 : wa_reg;
        cur_wb    = open ? 32'd0 : wb_reg;
        cur_tail  = open ? 24'd0 : tail_reg;

        placed   = {24'd0, s_data_byte} << {cur_pos[1:0], 3'b000};
        new_wa   = cur_wa;
        new_wb   = cur_wb;
        new_tail = cur_tail;
        if (s_has_byte) begin
            unique case (cur_pos[3:2])
                2'd0:    new_wa = cur_wa | placed;
                2'd1:    new_wb = cur_wb | placed;
                default: if (cur_pos != POS_LAST) begin
                    new_tail = cur_tail | placed[23:0];
                end
            endcase
        end
        blk     = s_has_byte && (cur_pos == POS_LAST);
        new_len = cur_len + {31'd0, s_has_byte};

        job.first  = cur_first;
        job.seed   = cur_seed;
        job.word_a = new_wa;
        job.word_b = new_wb;
        // a full block takes byte eleven on top; a closing tail sits one byte up
        job.word_c = blk ? {s_data_byte, cur_tail} : {new_tail, 8'd0};
        job.length = new_len;
        job.blk    = blk;
        job.fin    = s_last_byte;
        job_push   = accept && (blk || s_last_byte);

        in_key_next = in_key_reg;
        first_next  = first_reg;
        seed_next   = seed_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        wa_next     = wa_reg;
        wb_next     = wb_reg;
        tail_next   = tail_reg;
        if (accept) begin
            in_key_next = !s_last_byte;
            first_next  = cur_first && !job_push;
            seed_next   = cur_seed;
            len_next    = new_len;
            if (s_has_byte) begin
                pos_next = blk ? 4'd0 : cur_pos + 4'd1;
            end else begin
                pos_next = cur_pos;
            end
            wa_next   = job_push ? 32'd0 : new_wa;
            wb_next   = job_push ? 32'd0 : new_wb;
            tail_next = job_push ? 24'd0 : new_tail;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg <= 1'b0;
        end else begin
            in_key_reg <= in_key_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        seed_reg  <= seed_next;
        pos_reg   <= pos_next;
        len_reg   <= len_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        tail_reg  <= tail_next;
    end

endmodule
`default_nettype wire

[rtl/lkh_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lkh_back
// Adds queued words into a, b and c and mixes them one row per cycle.
// ----------------------------------------------------------------------------
module lkh_back
    import lkh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire lkh_q_stat_t q_stat,
    input  wire lkh_job_t    job,
    output logic             job_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hash_value
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  row_reg, row_next;
    logic        fin_pend_reg, fin_pend_next;
    logic        emit_pend_reg, emit_pend_next;
    logic [31:0] len_reg, len_next;
    lkh_abc_t    abc_reg, abc_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] hash_reg, hash_next;

    lkh_abc_t    base;

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        fin_pend_next  = fin_pend_reg;
        emit_pend_next = emit_pend_reg;
        len_next       = len_reg;
        abc_next       = abc_reg;
        hash_next      = hash_reg;
        m_valid_next   = m_valid_reg;
        job_pop        = 1'b0;

        base.a = job.first ? GOLDEN_RATIO : abc_reg.a;
        base.b = job.first ? GOLDEN_RATIO : abc_reg.b;
        base.c = job.first ? job.seed : abc_reg.c;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    job_pop    = 1'b1;
                    abc_next.a = base.a + job.word_a;
                    abc_next.b = base.b + job.word_b;
                    abc_next.c = base.c + job.word_c;
                    len_next   = job.length;
                    row_next   = 4'd0;
                    if (job.blk) begin
                        state_next     = ST_MIX;
                        fin_pend_next  = job.fin;
                        emit_pend_next = 1'b0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                abc_next.c     = abc_reg.c + len_reg;
                fin_pend_next  = 1'b0;
                emit_pend_next = 1'b1;
                row_next       = 4'd0;
                state_next     = ST_MIX;
            end
            ST_MIX: begin
                abc_next = mix_row(abc_reg, row_reg);
                row_next = row_reg + 4'd1;
                if (row_reg == MIX_LAST_ROW) begin
                    priority if (fin_pend_reg) begin
                        state_next = ST_FIN;
                    end else if (emit_pend_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    hash_next    = abc_reg.c;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_reg       <= 4'd0;
            fin_pend_reg  <= 1'b0;
            emit_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            fin_pend_reg  <= fin_pend_next;
            emit_pend_reg <= emit_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        abc_reg  <= abc_next;
        hash_reg <= hash_next;
    end

endmodule
`default_nettype wire

[rtl/lookup2_key_hash_top.sv]
// ----------------------------------------------------------------------------
// lookup2_key_hash_top - streaming lookup2 key hash, one key byte per word
// Throughput: one byte per cycle while the job queue has room; the single mixing
// row unit mixes once per 12-byte block and once per key close.
// Sync reset clears all control.
// ----------------------------------------------------------------------------
`default_nettype none
module lookup2_key_hash_top
    import lkh_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last_byte,
    input  wire logic [31:0] s_seed,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_hash_value
);

    // Front end: pack bytes little-endian into the a, b and c words of the
    // current block, count the key length and open a key on its first word,
    // capturing the seed there. A job is queued for every full block and for
    // the closing word; a block that ends on the closing word is one job with
    // both the block and close flags set.
    lkh_job_t    push_job;
    lkh_job_t    head_job;
    logic        job_push;
    logic        job_pop;
    lkh_q_stat_t q_stat;

    lkh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_has_byte  (s_has_byte),
        .s_last_byte (s_last_byte),
        .s_seed      (s_seed),
        .q_stat      (q_stat),
        .job_push    (job_push),
        .job         (push_job)
    );

    // Job queue: let the front keep taking bytes while the back end mixes.
    lkh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    // Back end: add the job words into a, b and c (from the golden ratio and
    // seed on a key's first job), run the nine mixing rows on a full block, and
    // on a close add the length, then mix and hand c to the output register.
    lkh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .job          (head_job),
        .job_pop      (job_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

`ifndef SYNTHESIS
    // never pop an empty queue
    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    // never push into a full queue
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> !q_stat.full)
        else $error("job pushed into full queue");

    // a lone push leaves the queue holding a job
    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push && !job_pop |=> !q_stat.empty)
        else $error("pushed job lost");

    // reset drops any pending result
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");
`endif

endmodule
`default_nettype wire

[tb/sv/lookup2_key_hash_top_tb.sv]
// ----------------------------------------------------------------------------
// lookup2_key_hash_top_tb
// Self-checking bench for the streaming lookup2 key hash. Keys are fed one
// byte per word, and each hash that comes out is compared with one worked
// out here, key by key. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none
module lookup2_key_hash_top_tb;
    import lkh_pkg::GOLDEN_RATIO;

    localparam int unsigned QUIET_LIMIT = 2000; // cycles with no word moved
    localparam int unsigned HOLD_CYCLES = 300;  // long receiver hold-off
    localparam int unsigned DRAIN_WAIT  = 40;   // settle time after the last drain
    localparam int unsigned WORDS_WANTED = 450;

    // ------------------------------------------------------------------------
    // Hash predictor and store of expected hashes
    // ------------------------------------------------------------------------
    class lookup2_scoreboard;
        bit [31:0] acc_a, acc_b, acc_c;
        bit [3:0]  blk_pos;
        bit [23:0] c_tail;
        bit [31:0] key_len;
        bit        key_open;
        bit [31:0] expected_hashes[$];
        int        failures;
        int        hashes_checked;

        function new();
            key_open       = 1'b0;
            failures       = 0;
            hashes_checked = 0;
        endfunction

        // one pass of the three-way mix
        function void scramble();
            acc_a = acc_a - acc_b; acc_a = acc_a - acc_c; acc_a = acc_a ^ (acc_c >> 13);
            acc_b = acc_b - acc_c; acc_b = acc_b - acc_a; acc_b = acc_b ^ (acc_a << 8);
            acc_c = acc_c - acc_a; acc_c = acc_c - acc_b; acc_c = acc_c ^ (acc_b >> 13);
            acc_a = acc_a - acc_b; acc_a = acc_a - acc_c; acc_a = acc_a ^ (acc_c >> 12);
            acc_b = acc_b - acc_c; acc_b = acc_b - acc_a; acc_b = acc_b ^ (acc_a << 16);
            acc_c = acc_c - acc_a; acc_c = acc_c - acc_b; acc_c = acc_c ^ (acc_b >> 5);
            acc_a = acc_a - acc_b; acc_a = acc_a - acc_c; acc_a = acc_a ^ (acc_c >> 3);
            acc_b = acc_b - acc_c; acc_b = acc_b - acc_a; acc_b = acc_b ^ (acc_a << 10);
            acc_c = acc_c - acc_a; acc_c = acc_c - acc_b; acc_c = acc_c ^ (acc_b >> 15);
        endfunction

        // advance the key state by one accepted word
        function void note_word(bit [7:0] kb, bit has, bit last, bit [31:0] seed);
            bit [31:0] lane_val;
            if (!key_open) begin
                acc_a    = GOLDEN_RATIO;
                acc_b    = GOLDEN_RATIO;
                acc_c    = seed;
                blk_pos  = '0;
                c_tail   = '0;
                key_len  = '0;
                key_open = 1'b1;
            end
            if (has) begin
                lane_val = {24'h0, kb} << (8 * blk_pos[1:0]);
                if (blk_pos < 4) begin
                    acc_a = acc_a + lane_val;
                end else if (blk_pos < 8) begin
                    acc_b = acc_b + lane_val;
                end else if (blk_pos < 11) begin
                    c_tail = c_tail | lane_val[23:0];
                end else begin
                    acc_c  = acc_c + {kb, c_tail};
                    c_tail = '0;
                    scramble();
                end
                blk_pos = (blk_pos >= 11) ? 4'd0 : blk_pos + 4'd1;
                key_len = key_len + 32'd1;
            end
            if (last) begin
                acc_c = acc_c + key_len;
                acc_c = acc_c + {c_tail, 8'h00};
                scramble();
                expected_hashes.push_back(acc_c);
                key_open = 1'b0;
                blk_pos  = '0;
                c_tail   = '0;
                key_len  = '0;
            end
        endfunction

        function void check_hash(bit [31:0] got);
            bit [31:0] want;
            if (expected_hashes.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected hash %08h with nothing outstanding", got);
                return;
            end
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display("hash wrong: expected %08h, got %08h", want, got);
            end
        endfunction

        function int pending();
            return expected_hashes.size();
        endfunction

        // count hashes that never arrived
        function void close_out();
            if (expected_hashes.size() != 0) begin
                $display("%0d hashes never arrived", expected_hashes.size());
                failures += expected_hashes.size();
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; the driven ones are known from time zero
    // ------------------------------------------------------------------------
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte  = 8'h00;
    logic        s_has_byte   = 1'b0;
    logic        s_last_byte  = 1'b0;
    logic [31:0] s_seed       = 32'h0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [31:0] m_hash_value;

    always #5 aclk = ~aclk;

    lookup2_key_hash_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_has_byte   (s_has_byte),
        .s_last_byte  (s_last_byte),
        .s_seed       (s_seed),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    lookup2_scoreboard sb = new();

    int unsigned idle_pct  = 0;   // chance the sender sits out a cycle
    int unsigned stall_pct = 0;   // chance the receiver drops ready
    int unsigned n_words   = 0;
    int unsigned n_bytes   = 0;
    int unsigned n_keys    = 0;
    int unsigned longest   = 0;
    int unsigned quiet     = 0;

    // the main process flips hold_kick; the receiver owns the hold-off count
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_kick;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready   <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: note every accepted key word, check every accepted hash,
    // and drop out if nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(s_data_byte, s_has_byte, s_last_byte, s_seed);
            if (m_valid && m_ready)
                sb.check_hash(m_hash_value);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("no word moved for %0d cycles", QUIET_LIMIT);
                $display("lookup2_key_hash_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one word, idling first at random; return at the edge it is taken.
    // Valid stays high afterwards, so the caller either offers the next word
    // at once or drops valid.
    task automatic send_word(input logic [7:0] kb, input logic has, input logic last,
                             input logic [31:0] seed);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= kb;
        s_has_byte  <= has;
        s_last_byte <= last;
        s_seed      <= seed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_words++;
        if (has) n_bytes++;
    endtask

    // Send a whole key of n bytes with random content. Empty words are
    // scattered in at noise_pct; some keys close on an extra empty word.
    task automatic send_key(input int unsigned n, input int unsigned noise_pct);
        logic [31:0] key_seed;
        logic [7:0]  kb;
        bit          first;
        bit          empty_close;
        int unsigned r;
        r = $urandom_range(9);
        key_seed    = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : $urandom();
        empty_close = (n == 0) || ($urandom_range(4) == 0);
        first       = 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_word(8'($urandom_range(255)), 1'b0, 1'b0,
                          first ? key_seed : $urandom());
                first = 1'b0;
            end
            r  = $urandom_range(7);
            kb = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(255));
            send_word(kb, 1'b1, (i == n - 1) && !empty_close, first ? key_seed : $urandom());
            first = 1'b0;
        end
        if (empty_close)
            send_word(8'($urandom_range(255)), 1'b0, 1'b1, first ? key_seed : $urandom());
        n_keys++;
        if (n > longest) longest = n;
    endtask

    // Drop valid and hold off until every hash owed has come back. Wait for the
    // next edge first so the monitor has noted the word just taken.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned target;
        int unsigned n;
        int unsigned r;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed keys, no idling.
        // empty key under both seed extremes
        send_word(8'h00, 1'b0, 1'b1, 32'h0000_0000);
        send_word(8'hff, 1'b0, 1'b1, 32'hffff_ffff);
        // one-byte keys at both byte extremes
        send_word(8'hff, 1'b1, 1'b1, 32'ha5a5_5a5a);
        send_word(8'h00, 1'b1, 1'b1, 32'hffff_ffff);
        // a full block that ends on the closing byte: mix, then mix again
        for (int i = 0; i < 12; i++)
            send_word(8'hff, 1'b1, i == 11, (i == 0) ? 32'h0 : 32'hffff_ffff);
        // opens on an empty word, empty word mid-key, closes on an empty word
        send_word(8'h5a, 1'b0, 1'b0, 32'h1234_5678);
        send_word(8'h80, 1'b1, 1'b0, 32'hdead_beef);
        send_word(8'h33, 1'b0, 1'b0, 32'h0);
        send_word(8'h01, 1'b1, 1'b0, 32'hffff_ffff);
        send_word(8'hc3, 1'b0, 1'b1, 32'h0);
        drain();

        // Random keys over four idling phases. Phase 0 starts with the long
        // receiver hold-off, so the block fills and backs up its input.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 23; stall_pct = 23; end
            endcase
            if (ph == 0) hold_kick <= ~hold_kick;
            target = n_words + WORDS_WANTED / 4;
            while (n_words < target) begin
                // favour sizes around block edges, with a few long keys
                r = $urandom_range(19);
                if (r < 4)
                    n = $urandom_range(3);
                else if (r < 10)
                    n = 12 * $urandom_range(1, 2) + $urandom_range(2) - 1;
                else if (r < 19)
                    n = $urandom_range(30);
                else
                    n = $urandom_range(40, 64);
                send_key(n, 10);
            end
            drain();
        end

        // let any trailing work settle, then close out
        repeat (DRAIN_WAIT) @(posedge aclk);
        sb.close_out();

        $display("covered %0d keys in %0d words (%0d bytes), longest %0d bytes; %0d hashes checked",
                 n_keys, n_words, n_bytes, longest, sb.hashes_checked);
        $display("idling: none, sender, receiver, both; one %0d-cycle receiver hold-off",
                 HOLD_CYCLES);
        if (sb.failures == 0) begin
            $display("lookup2_key_hash_top: match");
        end else begin
            $display("%0d failures", sb.failures);
            $display("lookup2_key_hash_top: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
